@@ src/ucs_pkg.sv @@
// url component splitter: shared types and constants
// phase codes, component tags, character codes, tracker state record
// no dependencies
package ucs_pkg;

   // characters that steer the phase
   localparam logic [7:0] ChColon    = 8'h3A;
   localparam logic [7:0] ChSlash    = 8'h2F;
   localparam logic [7:0] ChQuestion = 8'h3F;
   localparam logic [7:0] ChHash     = 8'h23;
   localparam logic [7:0] ChNewline  = 8'h0A;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;

   // bytes skipped after the scheme colon, counting the colon itself
   localparam logic [1:0] SchemeSkip = 2'd3;

   // saturation limit of the port accumulator
   localparam logic [15:0] PortMax = 16'hFFFF;

   // component tag written into each result
   typedef enum logic [2:0] {
      PART_SCHEME = 3'd0,
      PART_HOST   = 3'd1,
      PART_PORT   = 3'd2,
      PART_PATH   = 3'd3,
      PART_QUERY  = 3'd4,
      PART_FRAG   = 3'd5,
      PART_DELIM  = 3'd6
   } part_type;

   // parser phase
   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_HOST   = 3'd1,
      PH_PORT   = 3'd2,
      PH_PATH   = 3'd3,
      PH_QUERY  = 3'd4,
      PH_FRAG   = 3'd5,
      PH_SKIP   = 3'd6
   } phase_type;

   // state carried from one byte to the next
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  slash_skip;
      logic [15:0] port_acc;
      logic        port_seen;
   } track_type;

   localparam track_type TrackReset = '{
      phase:      PH_SCHEME,
      slash_skip: 2'd0,
      port_acc:   16'd0,
      port_seen:  1'b0
   };

endpackage

@@ src/ucs_channels.sv @@
// url component splitter: request and response channel interfaces
// valid/ready handshake, a transaction moves when both are high
// no dependencies
interface ucs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ucs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [2:0]  part;
   logic [15:0] port_value;
   logic        port_given;
   logic        url_done;

   modport source (output valid, output out_byte, output part, output port_value,
                   output port_given, output url_done, input ready);
   modport sink   (input valid, input out_byte, input part, input port_value,
                   input port_given, input url_done, output ready);
endinterface

@@ src/ucs_classify.sv @@
// url component splitter: per-byte classification and state update
// pure combinational, depends on ucs_pkg
module ucs_classify (
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  ucs_pkg::track_type track,
   output ucs_pkg::part_type  part,
   output logic [15:0]        port_value,
   output logic               port_given,
   output ucs_pkg::track_type track_next
);
   import ucs_pkg::*;

   logic        is_digit;
   logic [19:0] port_mac;
   logic [15:0] port_sat;
   track_type   upd;

   // port digit accumulate: acc*10 + digit as shifts and adds, then saturate
   assign is_digit = (in_byte >= ChZero) && (in_byte <= ChNine);
   assign port_mac = {1'b0, track.port_acc, 3'b000} + {3'b000, track.port_acc, 1'b0}
                     + {16'd0, in_byte[3:0]};
   assign port_sat = (port_mac > {4'd0, PortMax}) ? PortMax : port_mac[15:0];

   // phase transitions and tags
   always_comb begin
      upd  = track;
      part = PART_DELIM;
      if (in_last && (in_byte == ChNewline)) begin
         part = PART_DELIM;
      end else begin
         case (track.phase)
            PH_SKIP: begin
               if (track.slash_skip > 2'd1) begin
                  upd.slash_skip = track.slash_skip - 2'd1;
               end else begin
                  upd.slash_skip = 2'd0;
                  upd.phase      = PH_HOST;
               end
            end
            PH_HOST: begin
               if (in_byte == ChColon) begin
                  upd.phase = PH_PORT;
               end else if (in_byte == ChSlash) begin
                  upd.phase = PH_PATH;
               end else if (in_byte == ChQuestion) begin
                  upd.phase = PH_QUERY;
               end else if (in_byte == ChHash) begin
                  upd.phase = PH_FRAG;
               end else begin
                  part = PART_HOST;
               end
            end
            PH_PORT: begin
               if (in_byte == ChSlash) begin
                  upd.phase = PH_PATH;
               end else if (in_byte == ChQuestion) begin
                  upd.phase = PH_QUERY;
               end else if (in_byte == ChHash) begin
                  upd.phase = PH_FRAG;
               end else begin
                  part = PART_PORT;
                  if (is_digit) begin
                     upd.port_acc  = port_sat;
                     upd.port_seen = 1'b1;
                  end
               end
            end
            PH_PATH: begin
               if (in_byte == ChQuestion) begin
                  upd.phase = PH_QUERY;
               end else if (in_byte == ChHash) begin
                  upd.phase = PH_FRAG;
               end else begin
                  part = PART_PATH;
               end
            end
            PH_QUERY: begin
               if (in_byte == ChHash) begin
                  upd.phase = PH_FRAG;
               end else begin
                  part = PART_QUERY;
               end
            end
            PH_FRAG: begin
               part = PART_FRAG;
            end
            default: begin
               if (in_byte == ChColon) begin
                  upd.phase      = PH_SKIP;
                  upd.slash_skip = SchemeSkip - 2'd1;
               end else begin
                  upd.phase = PH_SCHEME;
                  part      = PART_SCHEME;
               end
            end
         endcase
      end
   end

   // report values after this byte, then return to reset at end of url
   assign port_value = upd.port_acc;
   assign port_given = upd.port_seen;
   assign track_next = in_last ? TrackReset : upd;

endmodule

@@ src/url_component_splitter_top.sv @@
// url component splitter: top level with input register, tracker and result register
// depends on ucs_pkg, ucs_channels (ucs_req_if, ucs_rsp_if) and ucs_classify
//
// Takes a URL one byte per transaction (last flag on the final byte) and returns one
// result per byte: the byte, its component tag (scheme, host, port, path, query,
// fragment, or delimiter/dropped), the port accumulated so far and whether a port
// digit was seen. Throughput is one byte per clock while the response side is ready;
// the phase tracker updates as a byte moves from the input register to the result
// register, which drives the valid response. Both registers
// hold a byte under backpressure; while a finished result waits, one more request
// is taken into the empty input register. State returns to reset after each last
// byte.
module url_component_splitter_top (
   input logic     clock,
   input logic     reset,
   ucs_req_if.sink   req_bus,
   ucs_rsp_if.source rsp_bus
);
   import ucs_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   part_type    out_part_ff;
   logic [15:0] out_port_ff;
   logic        out_given_ff;
   logic        out_done_ff;

   track_type track_ff;
   track_type track_in;
   part_type  cls_part;
   logic [15:0] cls_port;
   logic        cls_given;

   logic advance;
   logic take;

   // handshake: move the input stage forward when the result slot frees
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   // classification of the byte in the input register
   ucs_classify u_classify (
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .track      (track_ff),
      .part       (cls_part),
      .port_value (cls_port),
      .port_given (cls_given),
      .track_next (track_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         track_ff     <= TrackReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            track_ff <= track_in;
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_bus.in_byte;
         in_last_ff <= req_bus.in_last;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff  <= in_byte_ff;
         out_part_ff  <= cls_part;
         out_port_ff  <= cls_port;
         out_given_ff <= cls_given;
         out_done_ff  <= in_last_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_byte   = out_byte_ff;
   assign rsp_bus.part       = out_part_ff;
   assign rsp_bus.port_value = out_port_ff;
   assign rsp_bus.port_given = out_given_ff;
   assign rsp_bus.url_done   = out_done_ff;

endmodule
